>>> rtl/swq_pkg.sv
`timescale 1ns / 1ps
package swq_pkg;

    localparam int WAKE_W       = 32;
    localparam int ID_W         = 4;
    localparam int PRIO_W       = 8;
    localparam int RQI_W        = 6;
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    localparam logic [RQI_W-1:0]  RQI_MAX   = 6'd63;
    localparam logic [WAKE_W-1:0] WAKE_SAT  = {WAKE_W{1'b1}};

    // request action codes
    localparam logic ACT_SLEEP = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [WAKE_W-1:0] wake;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

>>> rtl/swq_if.sv
`timescale 1ns / 1ps
interface swq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [swq_pkg::ID_W-1:0]    task_id;
    logic [swq_pkg::PRIO_W-1:0]  task_priority;
    logic [swq_pkg::WAKE_W-1:0]  now;
    logic [swq_pkg::WAKE_W-1:0]  duration;

    modport source (output valid, action, task_id, task_priority, now, duration,
                    input ready);
    modport sink   (input valid, action, task_id, task_priority, now, duration,
                    output ready);
endinterface

interface swq_out_if;
    logic                        valid;
    logic                        ready;
    logic [swq_pkg::ID_W-1:0]    woken_id;
    logic [swq_pkg::RQI_W-1:0]   run_queue_index;
    logic                        last;

    modport source (output valid, woken_id, run_queue_index, last, input ready);
    modport sink   (input valid, woken_id, run_queue_index, last, output ready);
endinterface

>>> rtl/sleep_wake_timer_queue.sv
`timescale 1ns / 1ps
// sleep request: accepted in idle, entry lands in the cell chain in the following cycle
// (a full queue drops it); tick request: one woken task leaves per cycle from the chain head
// while the output is free, at most 16 per tick; a new request is taken only back in idle
// each result of a tick is loaded from the wake state into an output register and held there
// reset (i_rst_n, synchronous, active low) empties the queue and drops any pending result
module sleep_wake_timer_queue #(
    parameter int MAX_TASKS   = 16,
    parameter int BUCKET_SPAN = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swq_in_if.sink     i_req,
    swq_out_if.source  o_res
);

    // bucket index by reciprocal multiply, exact for 8-bit priorities and spans up to 64
    localparam int RQI_SHIFT = 16;
    localparam logic [RQI_SHIFT:0] RQI_RECIP =
        (RQI_SHIFT + 1)'(((1 << RQI_SHIFT) + BUCKET_SPAN - 1) / BUCKET_SPAN);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_WAKE
    } t_state;

    t_state r_state, n_state;

    // captured request fields
    logic [swq_pkg::WAKE_W-1:0] r_new_wake, n_new_wake;
    logic [swq_pkg::ID_W-1:0]   r_new_id, n_new_id;
    logic [swq_pkg::PRIO_W-1:0] r_new_prio, n_new_prio;
    logic [swq_pkg::WAKE_W-1:0] r_now, n_now;
    logic [swq_pkg::CNT_W-1:0]  r_wake_cnt, n_wake_cnt;

    // output register
    logic                       r_out_valid, n_out_valid;
    logic [swq_pkg::ID_W-1:0]   r_out_id, n_out_id;
    logic [swq_pkg::RQI_W-1:0]  r_out_rqi, n_out_rqi;
    logic                       r_out_last, n_out_last;

    // cell chain wiring
    swq_pkg::t_entry    w_ent   [MAX_TASKS];
    swq_pkg::t_entry    w_prev  [MAX_TASKS];
    swq_pkg::t_entry    w_next  [MAX_TASKS];
    logic               w_keep  [MAX_TASKS];
    logic               w_pkeep [MAX_TASKS];
    logic [MAX_TASKS-1:0] w_valid_vec;
    swq_pkg::t_cell_ctl w_ctl;

    logic                       w_accept;
    logic [swq_pkg::WAKE_W:0]   w_sum;
    logic                       w_front_due;
    logic                       w_second_due;
    logic                       w_out_free;
    logic                       w_pop;
    logic                       w_last;
    logic [swq_pkg::PRIO_W+RQI_SHIFT-1:0] w_prod;
    logic [swq_pkg::PRIO_W-1:0] w_quot;

    genvar k;
    generate
        for (k = 0; k < MAX_TASKS; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign w_prev[k]  = '0;
                assign w_pkeep[k] = 1'b1;
            end else begin : g_body
                assign w_prev[k]  = w_ent[k-1];
                assign w_pkeep[k] = w_keep[k-1];
            end
            if (k == MAX_TASKS - 1) begin : g_tail
                assign w_next[k] = '0;
            end else begin : g_inner
                assign w_next[k] = w_ent[k+1];
            end
            assign w_valid_vec[k] = w_ent[k].valid;

            swq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_prev      (w_prev[k]),
                .i_prev_keep (w_pkeep[k]),
                .i_next      (w_next[k]),
                .o_entry     (w_ent[k]),
                .o_keep      (w_keep[k])
            );
        end
    endgenerate

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // saturating wake time
    assign w_sum = {1'b0, i_req.now} + {1'b0, i_req.duration};

    // head due checks against the tick's time stamp
    assign w_front_due  = w_ent[0].valid && (w_ent[0].wake <= r_now);
    assign w_second_due = w_ent[1].valid && (w_ent[1].wake <= r_now);
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_pop        = (r_state == S_WAKE) && w_front_due && w_out_free;
    // last when the next head is not due or the per-tick limit is reached
    assign w_last = !(w_second_due &&
                      (r_wake_cnt < swq_pkg::CNT_W'(swq_pkg::RESULT_LIMIT - 1)));

    // run-queue bucket of the head entry
    assign w_prod = {{RQI_SHIFT{1'b0}}, w_ent[0].prio}
                  * {{(swq_pkg::PRIO_W - 1){1'b0}}, RQI_RECIP};
    assign w_quot = w_prod[swq_pkg::PRIO_W+RQI_SHIFT-1:RQI_SHIFT];

    // full queue drops the sleep request
    assign w_ctl.ins       = (r_state == S_INSERT) && !w_ent[MAX_TASKS-1].valid;
    assign w_ctl.pop       = w_pop;
    assign w_ctl.new_entry = '{valid: 1'b1, wake: r_new_wake, id: r_new_id, prio: r_new_prio};

    always_comb begin
        n_state     = r_state;
        n_new_wake  = r_new_wake;
        n_new_id    = r_new_id;
        n_new_prio  = r_new_prio;
        n_now       = r_now;
        n_wake_cnt  = r_wake_cnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_id    = r_out_id;
        n_out_rqi   = r_out_rqi;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_now      = i_req.now;
                    n_new_id   = i_req.task_id;
                    n_new_prio = i_req.task_priority;
                    n_new_wake = w_sum[swq_pkg::WAKE_W] ? swq_pkg::WAKE_SAT
                                                        : w_sum[swq_pkg::WAKE_W-1:0];
                    n_wake_cnt = '0;
                    n_state    = (i_req.action == swq_pkg::ACT_TICK) ? S_WAKE : S_INSERT;
                end
            end
            S_INSERT: begin
                n_state = S_IDLE;
            end
            S_WAKE: begin
                if (!w_front_due) begin
                    // nothing due at all
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = w_ent[0].id;
                    n_out_rqi   = (w_quot > swq_pkg::PRIO_W'(swq_pkg::RQI_MAX))
                                  ? swq_pkg::RQI_MAX : w_quot[swq_pkg::RQI_W-1:0];
                    n_out_last  = w_last;
                    n_wake_cnt  = r_wake_cnt + 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wake_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_wake_cnt  <= n_wake_cnt;
        end
        r_new_wake <= n_new_wake;
        r_new_id   <= n_new_id;
        r_new_prio <= n_new_prio;
        r_now      <= n_now;
        r_out_id   <= n_out_id;
        r_out_rqi  <= n_out_rqi;
        r_out_last <= n_out_last;
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.woken_id        = r_out_id;
    assign o_res.run_queue_index = r_out_rqi;
    assign o_res.last            = r_out_last;

`ifndef SYNTHESIS
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec >> 1) & ~w_valid_vec) == '0)
        else $error("occupied cells are not a contiguous run from the head");

    a_pop_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> r_out_valid)
        else $error("woken task left the queue without reaching the output");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wake_cnt <= swq_pkg::CNT_W'(swq_pkg::RESULT_LIMIT))
        else $error("per-tick wake count above limit");
`endif

endmodule

>>> rtl/swq_cell.sv
`timescale 1ns / 1ps
module swq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swq_pkg::t_cell_ctl i_ctl,
    input  swq_pkg::t_entry    i_prev,
    input  logic               i_prev_keep,
    input  swq_pkg::t_entry    i_next,
    output swq_pkg::t_entry    o_entry,
    output logic               o_keep
);

    logic                       r_valid;
    logic [swq_pkg::WAKE_W-1:0] r_wake;
    logic [swq_pkg::ID_W-1:0]   r_id;
    logic [swq_pkg::PRIO_W-1:0] r_prio;
    swq_pkg::t_entry            n_entry;

    // entry stays put when it wakes no later than the new one
    assign o_keep = r_valid && (r_wake <= i_ctl.new_entry.wake);

    always_comb begin
        n_entry = o_entry;
        if (i_ctl.ins && !o_keep) begin
            if (i_prev_keep) begin
                n_entry       = i_ctl.new_entry;
                n_entry.valid = 1'b1;
            end else begin
                n_entry = i_prev;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_wake <= n_entry.wake;
        r_id   <= n_entry.id;
        r_prio <= n_entry.prio;
    end

    assign o_entry = '{valid: r_valid, wake: r_wake, id: r_id, prio: r_prio};

`ifndef SYNTHESIS
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_next.valid) |-> (r_wake <= i_next.wake))
        else $error("queue order broken between neighbouring cells");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int MAX_TASKS       = 16;
    localparam int BUCKET_SPAN     = 4;
    localparam int RANDOM_ITEMS    = 180;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int DRAIN_TAIL      = 20;
    localparam int REPORT_LIMIT    = 10;
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // one request as offered on the input channel
    typedef struct {
        logic                       act;
        logic [swq_pkg::ID_W-1:0]   id;
        logic [swq_pkg::PRIO_W-1:0] prio;
        logic [swq_pkg::WAKE_W-1:0] now;
        logic [swq_pkg::WAKE_W-1:0] dur;
    } t_swq_req;

    // one woken task as it should leave the block
    typedef struct packed {
        logic [swq_pkg::ID_W-1:0]  id;
        logic [swq_pkg::RQI_W-1:0] rqi;
        logic                      last;
    } t_wakeup;

    // directed row: request plus, where obvious, the wake-up typed in by hand
    typedef struct {
        t_swq_req                  req;
        bit                        typed;
        int                        n_typed;
        logic [swq_pkg::ID_W-1:0]  t_id;
        logic [swq_pkg::RQI_W-1:0] t_rqi;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    swq_in_if  req_if ();
    swq_out_if res_if ();

    sleep_wake_timer_queue #(
        .MAX_TASKS   (MAX_TASKS),
        .BUCKET_SPAN (BUCKET_SPAN)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // shadow of the sleep queue, earliest wake time first
    logic [swq_pkg::WAKE_W-1:0] shadow_wake [MAX_TASKS];
    logic [swq_pkg::ID_W-1:0]   shadow_id   [MAX_TASKS];
    logic [swq_pkg::PRIO_W-1:0] shadow_prio [MAX_TASKS];
    int                         shadow_count;

    t_wakeup  step_wakeups [$];   // wake-ups caused by the latest request
    t_wakeup  pending_wakeups [$]; // wake-ups still owed by the block
    t_row     directed_rows [$];

    logic [swq_pkg::WAKE_W-1:0] sim_now;
    bit steady_mode;
    bit hold_off_req;
    bit hold_active;
    int fail_count;
    int sleeps_sent;
    int ticks_sent;
    int wakeups_checked;
    int deepest_queue;

    always #5 i_clk = ~i_clk;

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // predicts the queue update and the wake-ups for one accepted request
    function automatic void predict_request(input t_swq_req r);
        logic [swq_pkg::WAKE_W:0]   sum;
        logic [swq_pkg::WAKE_W-1:0] wake;
        int                         pos;
        int                         n;
        int                         quot;
        t_wakeup                    w;
        step_wakeups.delete();
        if (r.act == swq_pkg::ACT_SLEEP) begin
            sum  = {1'b0, r.now} + {1'b0, r.dur};
            wake = sum[swq_pkg::WAKE_W] ? swq_pkg::WAKE_SAT : sum[swq_pkg::WAKE_W-1:0];
            // a full queue drops the request
            if (shadow_count < MAX_TASKS) begin
                pos = 0;
                // equal wake times keep arrival order
                while (pos < shadow_count && shadow_wake[pos] <= wake)
                    pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_wake[k] = shadow_wake[k-1];
                    shadow_id[k]   = shadow_id[k-1];
                    shadow_prio[k] = shadow_prio[k-1];
                end
                shadow_wake[pos] = wake;
                shadow_id[pos]   = r.id;
                shadow_prio[pos] = r.prio;
                shadow_count++;
                if (shadow_count > deepest_queue)
                    deepest_queue = shadow_count;
            end
        end else begin
            n = 0;
            while (n < swq_pkg::RESULT_LIMIT && shadow_count > 0
                   && shadow_wake[0] <= r.now) begin
                quot  = int'(shadow_prio[0]) / BUCKET_SPAN;
                w.id  = shadow_id[0];
                w.rqi = (quot > int'(swq_pkg::RQI_MAX)) ? swq_pkg::RQI_MAX
                                                        : swq_pkg::RQI_W'(quot);
                // final wake-up of this tick: limit reached or next entry not yet due
                w.last = (n + 1 == swq_pkg::RESULT_LIMIT) || (shadow_count == 1)
                         || (shadow_wake[1] > r.now);
                step_wakeups.push_back(w);
                for (int k = 1; k < shadow_count; k++) begin
                    shadow_wake[k-1] = shadow_wake[k];
                    shadow_id[k-1]   = shadow_id[k];
                    shadow_prio[k-1] = shadow_prio[k];
                end
                shadow_count--;
                n++;
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly a coherent timeline of sleeps and ticks, some noise on top
    function automatic t_swq_req random_request();
        t_swq_req r;
        int       pick;
        int       dsel;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            sim_now = $urandom_range(0, 1)
                      ? swq_pkg::WAKE_W'($urandom)
                      : swq_pkg::WAKE_SAT - swq_pkg::WAKE_W'($urandom_range(0, 200));
        r.id   = swq_pkg::ID_W'($urandom_range(0, 15));
        r.prio = swq_pkg::PRIO_W'($urandom_range(0, 255));
        if (pick < 10) begin
            r.act = $urandom_range(0, 1) ? swq_pkg::ACT_TICK : swq_pkg::ACT_SLEEP;
            r.now = swq_pkg::WAKE_W'($urandom);
            r.dur = swq_pkg::WAKE_W'($urandom);
        end else if (pick < 62) begin
            r.act = swq_pkg::ACT_SLEEP;
            r.now = sim_now;
            dsel  = $urandom_range(0, 9);
            if (dsel < 8)
                r.dur = swq_pkg::WAKE_W'($urandom_range(0, 40));
            else if (dsel == 8)
                r.dur = swq_pkg::WAKE_W'($urandom_range(0, 600));
            else
                r.dur = swq_pkg::WAKE_W'($urandom);
        end else begin
            sim_now = sim_now + swq_pkg::WAKE_W'($urandom_range(0, 12));
            r.act   = swq_pkg::ACT_TICK;
            r.now   = sim_now;
            r.dur   = swq_pkg::WAKE_W'($urandom);
        end
        return r;
    endfunction

    // offer one request and hold it until the block takes it
    task automatic offer_request(input t_swq_req r, input bit typed, input int n_typed,
                                 input logic [swq_pkg::ID_W-1:0] t_id,
                                 input logic [swq_pkg::RQI_W-1:0] t_rqi);
        t_wakeup w;
        req_if.valid         <= 1'b1;
        req_if.action        <= r.act;
        req_if.task_id       <= r.id;
        req_if.task_priority <= r.prio;
        req_if.now           <= r.now;
        req_if.duration      <= r.dur;
        do
            @(posedge i_clk);
        while (req_if.ready !== 1'b1);
        predict_request(r);
        if (typed) begin
            if (n_typed > 0) begin
                w = '{id: t_id, rqi: t_rqi, last: 1'b1};
                pending_wakeups.push_back(w);
            end
        end else begin
            foreach (step_wakeups[k])
                pending_wakeups.push_back(step_wakeups[k]);
        end
        if (r.act == swq_pkg::ACT_SLEEP)
            sleeps_sent++;
        else
            ticks_sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic act, input int id, input int prio,
                           input logic [swq_pkg::WAKE_W-1:0] now,
                           input logic [swq_pkg::WAKE_W-1:0] dur,
                           input bit typed, input int n_typed, input int t_id, input int t_rqi);
        t_row row;
        row.req      = '{act: act, id: swq_pkg::ID_W'(id), prio: swq_pkg::PRIO_W'(prio),
                         now: now, dur: dur};
        row.typed    = typed;
        row.n_typed  = n_typed;
        row.t_id     = swq_pkg::ID_W'(t_id);
        row.t_rqi    = swq_pkg::RQI_W'(t_rqi);
        directed_rows.push_back(row);
    endtask

    // result side: random back-pressure, one long hold-off on request
    initial begin
        int run_len;
        int gap_len;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_active  = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_active  = 1'b0;
            end else if (steady_mode) begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run_len = $urandom_range(1, 12);
                gap_len = pick_gap();
                res_if.ready <= 1'b1;
                repeat (run_len) @(posedge i_clk);
                if (gap_len > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap_len) @(posedge i_clk);
                end
            end
        end
    end

    // compare every accepted wake-up with the oldest one owed
    always @(posedge i_clk) begin : check_wakeups
        t_wakeup want;
        t_wakeup got;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got = '{id: res_if.woken_id, rqi: res_if.run_queue_index, last: res_if.last};
            if (pending_wakeups.size() == 0) begin
                if (fail_count < REPORT_LIMIT)
                    $display("%0t: unexpected wake-up id=%0d rqi=%0d last=%0b",
                             $realtime, got.id, got.rqi, got.last);
                fail_count++;
            end else begin
                want = pending_wakeups.pop_front();
                wakeups_checked++;
                if (got.id !== want.id || got.rqi !== want.rqi || got.last !== want.last) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: exp id=%0d rqi=%0d last=%0b got id=%0d rqi=%0d last=%0b",
                                 $realtime, want.id, want.rqi, want.last,
                                 got.id, got.rqi, got.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_swq_req r;
        int       waited;
        i_clk        = 1'b0;
        shadow_count = 0;
        sim_now      = '0;
        steady_mode  = 1'b0;
        hold_off_req = 1'b0;
        hold_active  = 1'b0;
        fail_count   = 0;
        sleeps_sent  = 0;
        ticks_sent   = 0;
        wakeups_checked = 0;
        deepest_queue   = 0;
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.action        <= swq_pkg::ACT_SLEEP;
        req_if.task_id       <= '0;
        req_if.task_priority <= '0;
        req_if.now           <= '0;
        req_if.duration      <= '0;

        // act, id, prio, now, dur, typed, count, id, rqi
        add_row(swq_pkg::ACT_TICK,   9, 255, 32'h0000_0000, 32'hFFFF_FFFF, 1, 0, 0, 0); // empty
        add_row(swq_pkg::ACT_SLEEP,  0,   0, 32'h0000_0000, 32'h0000_0000, 1, 0, 0, 0);
        add_row(swq_pkg::ACT_TICK,   0,   0, 32'h0000_0000, 32'h0000_0000, 1, 1, 0, 0); // at once
        add_row(swq_pkg::ACT_SLEEP, 15, 255, 32'd10,        32'd5,         1, 0, 0, 0);
        add_row(swq_pkg::ACT_TICK,   0,   0, 32'd14,        32'd0,         1, 0, 0, 0); // early
        add_row(swq_pkg::ACT_TICK,   0,   0, 32'd15,        32'd0,         1, 1, 15, 63); // top
        add_row(swq_pkg::ACT_SLEEP,  3,   7, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1, 0, 0, 0); // sat
        add_row(swq_pkg::ACT_TICK,   0,   0, 32'hFFFF_FFFE, 32'd0,         1, 0, 0, 0);
        add_row(swq_pkg::ACT_TICK,   0,   0, 32'hFFFF_FFFF, 32'd0,         1, 1, 3, 1);
        add_row(swq_pkg::ACT_SLEEP, 12, 128, 32'h0000_0000, 32'hFFFF_FFFF, 1, 0, 0, 0); // top
        add_row(swq_pkg::ACT_SLEEP, 10,   3, 32'hFFFF_FFFF, 32'h0000_0000, 1, 0, 0, 0);
        add_row(swq_pkg::ACT_TICK,   0,   0, 32'hFFFF_FFFF, 32'd0,         0, 0, 0, 0);
        add_row(swq_pkg::ACT_SLEEP,  5,   8, 32'd100,       32'd20,        1, 0, 0, 0);
        add_row(swq_pkg::ACT_SLEEP,  6,  12, 32'd100,       32'd20,        1, 0, 0, 0); // tie
        add_row(swq_pkg::ACT_SLEEP,  7,   4, 32'd100,       32'd10,        1, 0, 0, 0); // front
        add_row(swq_pkg::ACT_SLEEP,  5, 200, 32'd101,       32'd19,        1, 0, 0, 0); // twice
        add_row(swq_pkg::ACT_TICK,   0,   0, 32'd119,       32'd0,         1, 1, 7, 1);
        add_row(swq_pkg::ACT_TICK,   0,   0, 32'd120,       32'd0,         0, 0, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            offer_request(directed_rows[k].req, directed_rows[k].typed,
                          directed_rows[k].n_typed, directed_rows[k].t_id,
                          directed_rows[k].t_rqi);
            idle_gap(pick_gap());
        end

        // fill the queue, one more sleep is dropped, then a tick wakes all sixteen
        for (int k = 0; k < MAX_TASKS; k++) begin
            r = '{act: swq_pkg::ACT_SLEEP, id: swq_pkg::ID_W'(k),
                  prio: swq_pkg::PRIO_W'(k * 17),
                  now: 32'd2000, dur: swq_pkg::WAKE_W'(k % 4)};
            offer_request(r, 1'b0, 0, '0, '0);
            idle_gap(pick_gap());
        end
        r = '{act: swq_pkg::ACT_SLEEP, id: 4'd15, prio: 8'd255, now: 32'd2000, dur: 32'd0};
        offer_request(r, 1'b0, 0, '0, '0);

        // result side parks while requests keep coming, so the input backs up
        req_if.valid <= 1'b0;
        hold_off_req = 1'b1;
        @(posedge i_clk);
        while (!hold_active)
            @(posedge i_clk);
        r = '{act: swq_pkg::ACT_TICK, id: 4'd0, prio: 8'd0, now: 32'd2003, dur: 32'd0};
        offer_request(r, 1'b0, 0, '0, '0);
        for (int k = 0; k < 4; k++) begin
            r = '{act: swq_pkg::ACT_SLEEP, id: swq_pkg::ID_W'($urandom_range(0, 15)),
                  prio: swq_pkg::PRIO_W'($urandom_range(0, 255)), now: 32'd2003,
                  dur: swq_pkg::WAKE_W'($urandom_range(0, 20))};
            offer_request(r, 1'b0, 0, '0, '0);
        end
        sim_now = 32'd2003;

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // a stretch with no idling on either side
            steady_mode = (k >= 90 && k < 130);
            r = random_request();
            offer_request(r, 1'b0, 0, '0, '0);
            idle_gap(pick_gap());
        end
        steady_mode = 1'b0;
        idle_gap(1);

        waited = 0;
        while (pending_wakeups.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (pending_wakeups.size() != 0) begin
            $display("%0d wake-ups never arrived", pending_wakeups.size());
            fail_count++;
        end

        $display("covered %0d sleep and %0d tick requests, %0d wake-ups compared",
                 sleeps_sent, ticks_sent, wakeups_checked);
        $display("deepest queue %0d of %0d, incl. full-queue drop, saturation and long stall",
                 deepest_queue, MAX_TASKS);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
